[hw/rtl/sfrp_pkg.sv]
// Shared types and constants of the frame resync parser.
`timescale 1ns / 1ps
`default_nettype none
package sfrp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LEN_W   = 6;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned K_W     = 7;
   localparam int unsigned IDX_W   = 2;

   localparam int unsigned HDR_BYTES   = 6;
   localparam int unsigned SKIP_BYTES  = 2;
   localparam int unsigned FRAME_EXTRA = 8;

   localparam int unsigned MAX_PAYLOAD_BYTES = 56;

   localparam logic [IDX_W-1:0] REG_SYNC_FIRST    = 2'd0;
   localparam logic [IDX_W-1:0] REG_SYNC_SECOND   = 2'd1;
   localparam logic [IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd181;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd98;
   localparam logic [LEN_W-1:0]  LIMIT_RST       = 6'd56;

   typedef struct packed {
      logic clear;
      logic add;
   } sum_ctl_type;

endpackage
`default_nettype wire

[hw/rtl/sync_frame_resync_parser.sv]
// Top level of the sync frame resync parser: sequencer, buffer and output register.
// A word is taken only in the idle state; results start once the hunt and checksum pass end.
// Each word then costs the hunt positions, a second-sync test where the first sync byte
// matches, a length read, a checksum check and an emitted frame, plus stalls.
// The single RAM read port sets this pace; results leave one a cycle when taken.
// Reset: synchronous, clears buffer fill, head, bad count, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module sync_frame_resync_parser import sfrp_pkg::*; #(
   parameter int unsigned BUFFER_BYTES      = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_byte_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_kind,
   output logic      [BYTE_W-1:0] rsp_frame_class,
   output logic      [BYTE_W-1:0] rsp_frame_id,
   output logic      [LEN_W-1:0]  rsp_frame_length,
   output logic      [BYTE_W-1:0] rsp_data_byte,
   output logic                   rsp_last,
   output logic      [CNT_W-1:0]  rsp_bad_frames,
   input  wire logic              csr_wr_en,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [BYTE_W-1:0] csr_wdata
);

   localparam int unsigned AW = $clog2(BUFFER_BYTES);
   localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned SW = CW + 8;
   localparam logic [CW:0] DEPTH_C = (CW+1)'(BUFFER_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_HUNT, ST_HUNT2, ST_LEN_LO, ST_LEN_HI, ST_SUM,
      ST_CK_A, ST_CK_B, ST_EMIT_H, ST_EMIT_P, ST_END
   } state_type;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= DEPTH_C) begin
         s = s - DEPTH_C;
      end
      return s[AW-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in, i_ff, i_in, off_ff, off_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]  bad_ff, bad_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [BYTE_W-1:0] lo_ff, lo_in, cls_ff, cls_in, id_ff, id_in;
   logic              amatch_ff, amatch_in;
   logic [BYTE_W-1:0] sync1_ff, sync2_ff;
   logic [LEN_W-1:0]  limit_ff;

   logic              rv_ff, rv_in, rk_ff, rk_in, rl_ff, rl_in;
   logic [BYTE_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0]  rb_ff, rb_in;
   logic [BYTE_W-1:0] rc_ff, rc_in, ri_ff, ri_in;
   logic [LEN_W-1:0]  rn_ff, rn_in;

   logic              wr_en, out_free, bad_inc;
   logic [CW-1:0]     wr_off;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] rd_q, sum_a, sum_b;
   sum_ctl_type       sum_ctl;
   logic [SW-1:0]     i_x, n_x, len_x, k_x;
   logic [15:0]       len16;

   sfrp_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte_in),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   sfrp_sum u_sum (
      .clock (clock),
      .ctl   (sum_ctl),
      .data  (rd_q),
      .sum_a (sum_a),
      .sum_b (sum_b)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign wr_en     = req_valid && req_ready;
   assign wr_off    = (CW'(fill_ff) == CW'(BUFFER_BYTES)) ? '0 : fill_ff;
   assign wr_addr   = wrap_add(head_ff, wr_off);
   assign rd_addr   = wrap_add(head_ff, off_in);
   assign out_free  = !rv_ff || rsp_ready;
   assign i_x       = SW'(i_ff);
   assign n_x       = SW'(fill_ff);
   assign len_x     = SW'(len_ff);
   assign k_x       = SW'(k_ff);
   assign len16     = {rd_q, lo_ff};

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      i_in      = i_ff;
      off_in    = off_ff;
      len_in    = len_ff;
      k_in      = k_ff;
      lo_in     = lo_ff;
      cls_in    = cls_ff;
      id_in     = id_ff;
      amatch_in = amatch_ff;
      bad_inc   = 1'b0;
      sum_ctl   = '0;
      rv_in     = rsp_ready ? 1'b0 : rv_ff;
      rk_in     = rk_ff;
      rl_in     = rl_ff;
      rd_in     = rd_ff;
      rb_in     = rb_ff;
      rc_in     = rc_ff;
      ri_in     = ri_ff;
      rn_in     = rn_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bad_inc  = (CW'(fill_ff) == CW'(BUFFER_BYTES));
               fill_in  = wr_off + CW'(1);
               i_in     = '0;
               off_in   = '0;
               state_in = ST_HUNT;
            end
         end
         ST_HUNT: begin
            if (!(i_x + SW'(1) < n_x)) begin
               state_in = ST_END;
            end else if (rd_q == sync1_ff) begin
               off_in   = CW'(i_x + SW'(1));
               state_in = ST_HUNT2;
            end else begin
               i_in   = CW'(i_x + SW'(1));
               off_in = CW'(i_x + SW'(1));
            end
         end
         ST_HUNT2: begin
            if (rd_q == sync2_ff) begin
               if (i_x + SW'(HDR_BYTES) > n_x) begin
                  state_in = ST_END;
               end else begin
                  off_in   = CW'(i_x + SW'(4));
                  state_in = ST_LEN_LO;
               end
            end else begin
               i_in     = CW'(i_x + SW'(1));
               off_in   = CW'(i_x + SW'(1));
               state_in = ST_HUNT;
            end
         end
         ST_LEN_LO: begin
            lo_in    = rd_q;
            off_in   = CW'(i_x + SW'(5));
            state_in = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            if (len16 > 16'(limit_ff) || len16 > 16'(MAX_PAYLOAD_BYTES)) begin
               bad_inc  = 1'b1;
               i_in     = CW'(i_x + SW'(SKIP_BYTES));
               off_in   = CW'(i_x + SW'(SKIP_BYTES));
               state_in = ST_HUNT;
            end else if (i_x + SW'(len16[LEN_W-1:0]) + SW'(FRAME_EXTRA) > n_x) begin
               state_in = ST_END;
            end else begin
               len_in        = len16[LEN_W-1:0];
               k_in          = '0;
               sum_ctl.clear = 1'b1;
               off_in        = CW'(i_x + SW'(2));
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_ctl.add = 1'b1;
            if (k_ff == '0) begin
               cls_in = rd_q;
            end
            if (k_ff == K_W'(1)) begin
               id_in = rd_q;
            end
            if (k_x == len_x + SW'(3)) begin
               off_in   = CW'(i_x + SW'(HDR_BYTES) + len_x);
               state_in = ST_CK_A;
            end else begin
               k_in   = k_ff + K_W'(1);
               off_in = CW'(i_x + SW'(3) + k_x);
            end
         end
         ST_CK_A: begin
            amatch_in = (rd_q == sum_a);
            off_in    = CW'(i_x + SW'(HDR_BYTES + 1) + len_x);
            state_in  = ST_CK_B;
         end
         ST_CK_B: begin
            if (amatch_ff && rd_q == sum_b) begin
               state_in = ST_EMIT_H;
            end else begin
               bad_inc  = 1'b1;
               i_in     = CW'(i_x + SW'(SKIP_BYTES));
               off_in   = CW'(i_x + SW'(SKIP_BYTES));
               state_in = ST_HUNT;
            end
         end
         ST_EMIT_H: begin
            if (out_free) begin
               rv_in = 1'b1;
               rk_in = 1'b0;
               rd_in = '0;
               rl_in = (len_ff == '0);
               rb_in = bad_ff;
               rc_in = cls_ff;
               ri_in = id_ff;
               rn_in = len_ff;
               k_in  = '0;
               if (len_ff == '0) begin
                  i_in     = CW'(i_x + SW'(FRAME_EXTRA));
                  state_in = ST_END;
               end else begin
                  off_in   = CW'(i_x + SW'(HDR_BYTES));
                  state_in = ST_EMIT_P;
               end
            end
         end
         ST_EMIT_P: begin
            if (out_free) begin
               rv_in = 1'b1;
               rk_in = 1'b1;
               rd_in = rd_q;
               rl_in = (k_x + SW'(1) == len_x);
               rb_in = bad_ff;
               if (k_x + SW'(1) == len_x) begin
                  i_in     = CW'(i_x + len_x + SW'(FRAME_EXTRA));
                  state_in = ST_END;
               end else begin
                  k_in   = k_ff + K_W'(1);
                  off_in = CW'(i_x + SW'(HDR_BYTES + 1) + k_x);
               end
            end
         end
         ST_END: begin
            head_in  = wrap_add(head_ff, i_ff);
            fill_in  = fill_ff - i_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign bad_in = (bad_inc && bad_ff != '1) ? bad_ff + CNT_W'(1) : bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
         bad_ff   <= '0;
         rv_ff    <= 1'b0;
         sync1_ff <= SYNC_FIRST_RST;
         sync2_ff <= SYNC_SECOND_RST;
         limit_ff <= LIMIT_RST;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         bad_ff   <= bad_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_SYNC_FIRST:    sync1_ff <= csr_wdata;
               REG_SYNC_SECOND:   sync2_ff <= csr_wdata;
               REG_PAYLOAD_LIMIT: limit_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      i_ff      <= i_in;
      off_ff    <= off_in;
      len_ff    <= len_in;
      k_ff      <= k_in;
      lo_ff     <= lo_in;
      cls_ff    <= cls_in;
      id_ff     <= id_in;
      amatch_ff <= amatch_in;
      rk_ff     <= rk_in;
      rl_ff     <= rl_in;
      rd_ff     <= rd_in;
      rb_ff     <= rb_in;
      rc_ff     <= rc_in;
      ri_ff     <= ri_in;
      rn_ff     <= rn_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_kind         = rk_ff;
   assign rsp_frame_class  = rc_ff;
   assign rsp_frame_id     = ri_ff;
   assign rsp_frame_length = rn_ff;
   assign rsp_data_byte    = rd_ff;
   assign rsp_last         = rl_ff;
   assign rsp_bad_frames   = rb_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(fill_ff) <= DEPTH_C) else $error("buffer fill beyond depth");
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(head_ff) < DEPTH_C) else $error("buffer head out of range");
   a_fill_after_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> fill_ff != '0) else $error("word not stored");
   a_bad_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> bad_ff >= $past(bad_ff)) else $error("bad count fell");
`endif

endmodule
`default_nettype wire

[hw/rtl/sfrp_ram.sv]
// Generic single write, single registered read RAM.
`timescale 1ns / 1ps
`default_nettype none
module sfrp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/sfrp_sum.sv]
// Fletcher-8 accumulator pair shared by the checksum pass.
`timescale 1ns / 1ps
`default_nettype none
module sfrp_sum import sfrp_pkg::*; (
   input  wire logic              clock,
   input  wire sum_ctl_type       ctl,
   input  wire logic [BYTE_W-1:0] data,
   output logic      [BYTE_W-1:0] sum_a,
   output logic      [BYTE_W-1:0] sum_b
);

   logic [BYTE_W-1:0] a_ff, b_ff, a_in, b_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctl.clear) begin
         a_in = '0;
         b_in = '0;
      end else if (ctl.add) begin
         a_in = a_ff + data;
         b_in = b_ff + a_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign sum_a = a_ff;
   assign sum_b = b_ff;

endmodule
`default_nettype wire
